// ===== rtl/cfcs_pkg.sv =====
// Types, codes and constants shared by the credit flow control sender.
package cfcs_pkg;

  localparam int CFCS_QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CC_STATUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEGIN_CODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRANT_CODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ABORT_CODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SESSION_CH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS  = 3'd6;

  localparam logic [15:0] WAIT_TICKS_RESET = 16'd384;
  localparam logic [16:0] ELAPSED_MAX      = 17'h1FFFF;

  // Input kind codes
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_RX      = 3'd1;
  localparam logic [2:0] KIND_SEND    = 3'd2;
  localparam logic [2:0] KIND_BEGIN   = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;
  localparam logic [2:0] KIND_ABORT   = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_RX,
    OP_SEND,
    OP_BEGIN,
    OP_END,
    OP_ABORT
  } op_t;

  typedef enum logic [2:0] {
    REP_NONE        = 3'd0,
    REP_SENT        = 3'd1,
    REP_WAITING     = 3'd2,
    REP_BUSY        = 3'd3,
    REP_DROPPED     = 3'd4,
    REP_DONE_OK     = 3'd5,
    REP_DONE_FAILED = 3'd6
  } report_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_CREDIT = 2'd1,
    MODE_BEGIN  = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0]  cc_status_code;
    logic [7:0]  begin_code;
    logic [7:0]  end_code;
    logic [7:0]  grant_code;
    logic [7:0]  abort_code;
    logic [6:0]  session_channel;
    logic [15:0] wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] rx_command;
    logic [7:0] rx_data;
    logic [6:0] channel;
    logic [7:0] send_status;
    logic [7:0] send_data1;
    logic [7:0] send_data2;
  } req_t;

  typedef struct packed {
    logic       emit_valid;
    logic [7:0] out_status;
    logic [7:0] out_data1;
    logic [7:0] out_data2;
    logic [2:0] report;
    logic       failed_flag;
    logic       active_flag;
    logic [3:0] credit_count;
  } rsp_t;

  // Classified command passed from front to back
  typedef struct packed {
    op_t         op;
    logic        rx_grant;
    logic        rx_abort;
    logic [7:0]  rx_data;
    logic [6:0]  channel;
    logic        ch_is_session;
    logic        send_ctrl;
    logic [23:0] msg;
  } cmd_t;

endpackage

// ===== rtl/cfcs_if.sv =====
// Valid/ready stream interfaces for the request and response channels.
interface cfcs_req_if
  import cfcs_pkg::*;
();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cfcs_rsp_if
  import cfcs_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cfcs_front.sv =====
// Front end: accepts request beats and classifies them into commands.
module cfcs_front
  import cfcs_pkg::*;
(
  cfcs_req_if.sink req,
  input  cfg_t     cfg,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_ready
);

  op_t op;

  always_comb begin
    case (req.data.kind)
      KIND_TICK:  op = OP_TICK;
      KIND_RX:    op = OP_RX;
      KIND_SEND:  op = OP_SEND;
      KIND_BEGIN: op = OP_BEGIN;
      KIND_END:   op = OP_END;
      KIND_ABORT: op = OP_ABORT;
      default:    op = OP_NOP;
    endcase
  end

  always_comb begin
    cmd.op            = op;
    // grant wins when grant and abort codes coincide
    cmd.rx_grant      = (req.data.rx_command == cfg.grant_code);
    cmd.rx_abort      = (req.data.rx_command == cfg.abort_code);
    cmd.rx_data       = req.data.rx_data;
    cmd.channel       = req.data.channel;
    cmd.ch_is_session = (req.data.channel == cfg.session_channel);
    cmd.send_ctrl     = (req.data.send_status == cfg.cc_status_code) &&
                        (req.data.send_data1 >= cfg.begin_code) &&
                        (req.data.send_data1 <= cfg.abort_code);
    cmd.msg           = {req.data.send_status, req.data.send_data1, req.data.send_data2};
  end

  assign cmd_valid = req.valid;
  assign req.ready = cmd_ready;

endmodule

// ===== rtl/cfcs_queue.sv =====
// Short command queue between the front and back ends.
module cfcs_queue
  import cfcs_pkg::*;
#(
  parameter int DEPTH = CFCS_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  cmd_t in_data,
  output logic in_ready,
  output logic out_valid,
  output cmd_t out_data,
  input  logic out_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/cfcs_back.sv =====
// Back end: executes commands against the link state and registers results.
module cfcs_back
  import cfcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_ready,
  cfcs_rsp_if.source rsp
);

  logic        flow_on, flow_on_next;
  logic [6:0]  flow_chan, flow_chan_next;
  logic [3:0]  credits_left, credits_left_next;
  logic        ack_waiting, ack_waiting_next;
  logic [6:0]  ack_chan, ack_chan_next;
  logic        session_failed, session_failed_next;
  mode_t       wait_mode, wait_mode_next;
  logic [16:0] elapsed_ticks, elapsed_ticks_next;
  logic [23:0] held_message;
  logic        hold_write;

  logic        out_valid;
  rsp_t        out_res, res;
  logic        pop;

  assign pop       = cmd_valid && (!out_valid || rsp.ready);
  assign cmd_ready = pop;

  always_comb begin
    logic [16:0] et;
    logic        busy;
    logic        uses;
    logic        ok;
    logic [2:0]  gch;
    logic [3:0]  gcr;
    report_t     rep;

    et    = elapsed_ticks;
    uses  = 1'b0;
    ok    = 1'b0;
    gch   = cmd.rx_data[6:4];
    gcr   = cmd.rx_data[3:0];
    rep   = REP_NONE;
    busy  = (cmd.op inside {OP_SEND, OP_BEGIN, OP_END, OP_ABORT}) &&
            (wait_mode != MODE_NONE);

    flow_on_next        = flow_on;
    flow_chan_next      = flow_chan;
    credits_left_next   = credits_left;
    ack_waiting_next    = ack_waiting;
    ack_chan_next       = ack_chan;
    session_failed_next = session_failed;
    wait_mode_next      = wait_mode;
    elapsed_ticks_next  = elapsed_ticks;
    hold_write          = 1'b0;

    res            = '0;

    if (busy) begin
      rep = REP_BUSY;
    end else begin
      case (cmd.op)
        OP_TICK: begin
          if (wait_mode != MODE_NONE) begin
            et = (elapsed_ticks == ELAPSED_MAX) ? elapsed_ticks : elapsed_ticks + 1'b1;
            elapsed_ticks_next = et;
            if (et > {1'b0, cfg.wait_ticks}) begin
              res.emit_valid = 1'b1;
              res.out_status = cfg.cc_status_code;
              res.out_data1  = cfg.abort_code;
              if (wait_mode == MODE_CREDIT) begin
                res.out_data2 = {1'b0, flow_chan};
                rep = REP_DROPPED;
              end else begin
                res.out_data2 = {1'b0, ack_chan};
                ack_waiting_next = 1'b0;
                rep = REP_DONE_FAILED;
              end
              flow_on_next        = 1'b0;
              credits_left_next   = '0;
              session_failed_next = 1'b1;
              wait_mode_next      = MODE_NONE;
            end
          end
        end
        OP_RX: begin
          if (cmd.rx_grant) begin
            if (gcr != '0) begin
              if (ack_waiting && (ack_chan == {4'b0, gch})) begin
                ack_waiting_next = 1'b0;
              end
              if (flow_on && (flow_chan == {4'b0, gch})) begin
                credits_left_next   = gcr;
                session_failed_next = 1'b0;
              end
            end
          end else if (cmd.rx_abort) begin
            flow_on_next        = 1'b0;
            credits_left_next   = '0;
            session_failed_next = 1'b1;
            if (cmd.rx_data == {1'b0, ack_chan}) begin
              ack_waiting_next = 1'b0;
            end
          end
          if (wait_mode == MODE_CREDIT) begin
            // release the held beat once credit arrives or flow stops
            if (!(flow_on_next && (credits_left_next == '0))) begin
              if (!session_failed_next) begin
                res.emit_valid = 1'b1;
                {res.out_status, res.out_data1, res.out_data2} = held_message;
                if (credits_left_next != '0) begin
                  credits_left_next = credits_left_next - 1'b1;
                end
                rep = REP_SENT;
              end else begin
                rep = REP_DROPPED;
              end
              wait_mode_next = MODE_NONE;
            end
          end else if ((wait_mode != MODE_NONE) && !ack_waiting_next) begin
            ok = !session_failed_next;
            if (wait_mode == MODE_BEGIN) begin
              if (ok && (ack_chan != cfg.session_channel)) begin
                flow_on_next = 1'b1;
              end
            end else if (ack_chan == flow_chan) begin
              flow_on_next      = 1'b0;
              credits_left_next = '0;
            end
            rep = ok ? REP_DONE_OK : REP_DONE_FAILED;
            wait_mode_next = MODE_NONE;
          end
        end
        OP_SEND: begin
          uses = flow_on && !cmd.send_ctrl;
          if (uses && (credits_left == '0)) begin
            hold_write         = 1'b1;
            wait_mode_next     = MODE_CREDIT;
            elapsed_ticks_next = '0;
            rep = REP_WAITING;
          end else if (uses && session_failed) begin
            rep = REP_DROPPED;
          end else begin
            res.emit_valid = 1'b1;
            {res.out_status, res.out_data1, res.out_data2} = cmd.msg;
            if (uses) begin
              credits_left_next = credits_left - 1'b1;
            end
            rep = REP_SENT;
          end
        end
        OP_BEGIN, OP_END: begin
          if (cmd.op == OP_BEGIN) begin
            flow_on_next        = !cmd.ch_is_session;
            flow_chan_next      = cmd.channel;
            credits_left_next   = '0;
            session_failed_next = 1'b0;
          end
          ack_chan_next    = cmd.channel;
          ack_waiting_next = 1'b1;
          res.emit_valid   = 1'b1;
          res.out_status   = cfg.cc_status_code;
          res.out_data1    = (cmd.op == OP_BEGIN) ? cfg.begin_code : cfg.end_code;
          res.out_data2    = {1'b0, cmd.channel};
          wait_mode_next   = (cmd.op == OP_BEGIN) ? MODE_BEGIN : MODE_END;
          elapsed_ticks_next = '0;
          rep = REP_WAITING;
        end
        OP_ABORT: begin
          res.emit_valid      = 1'b1;
          res.out_status      = cfg.cc_status_code;
          res.out_data1       = cfg.abort_code;
          res.out_data2       = {1'b0, cfg.session_channel};
          ack_waiting_next    = 1'b0;
          flow_on_next        = 1'b0;
          credits_left_next   = '0;
          session_failed_next = 1'b1;
        end
        default: begin
          rep = REP_NONE;
        end
      endcase
    end

    res.report       = rep;
    res.failed_flag  = session_failed_next;
    res.active_flag  = flow_on_next;
    res.credit_count = credits_left_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_on        <= 1'b0;
      flow_chan      <= '0;
      credits_left   <= '0;
      ack_waiting    <= 1'b0;
      ack_chan       <= '0;
      session_failed <= 1'b0;
      wait_mode      <= MODE_NONE;
      elapsed_ticks  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        flow_on        <= flow_on_next;
        flow_chan      <= flow_chan_next;
        credits_left   <= credits_left_next;
        ack_waiting    <= ack_waiting_next;
        ack_chan       <= ack_chan_next;
        session_failed <= session_failed_next;
        wait_mode      <= wait_mode_next;
        elapsed_ticks  <= elapsed_ticks_next;
        out_valid      <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= res;
    end
    if (pop && hold_write) begin
      held_message <= cmd.msg;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_res;

`ifndef SYNTHESIS
  a_credit_wait_state: assert property (@(posedge clk) disable iff (rst)
    (wait_mode == MODE_CREDIT) |-> (flow_on && (credits_left == '0)))
    else $error("credit wait without active flow at zero credit");

  a_ack_wait_mode: assert property (@(posedge clk) disable iff (rst)
    ack_waiting == ((wait_mode == MODE_BEGIN) || (wait_mode == MODE_END)))
    else $error("ack wait flag and wait mode disagree");

  a_pop_fills_output: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("executed command left no result beat");

  a_sent_emits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.report == REP_SENT)) |-> out_res.emit_valid)
    else $error("sent report without an emitted message");
`endif

endmodule

// ===== rtl/credit_flow_control_sender_unit.sv =====
// Credit flow control sender: top level with configuration registers.
//
// Usage: request beats enter on req (valid/ready); each beat is one event
// (tick, received flow message, send, begin, end, abort session). Every
// request beat yields exactly one response beat on rsp, in order, carrying
// the emitted three-byte message (if any), a report code and the flags
// after the event.
// Path: each request beat is written into the command queue, then executed
// in the execute stage, whose result register drives rsp.
// Throughput: one beat per cycle while rsp.ready stays high, set by the
// state update in the back end.
// Receiver stall: the result register holds while rsp.ready is low, the
// queue fills, and req.ready drops once it holds QUEUE_DEPTH commands.
// Reset (rst, synchronous): flow off, no credits, no wait, queue empty,
// registers back to their defaults. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it while no beat is in
// flight, which the block itself does not enforce; unknown indexes are ignored.
module credit_flow_control_sender_unit
  import cfcs_pkg::*;
#(
  parameter int QUEUE_DEPTH = CFCS_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cfcs_req_if.sink              req,
  cfcs_rsp_if.source            rsp
);

  cfg_t cfg;
  logic front_valid;
  cmd_t front_cmd;
  logic front_ready;
  logic back_valid;
  cmd_t back_cmd;
  logic back_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cc_status_code  <= 8'd0;
      cfg.begin_code      <= 8'd0;
      cfg.end_code        <= 8'd1;
      cfg.grant_code      <= 8'd2;
      cfg.abort_code      <= 8'd3;
      cfg.session_channel <= 7'd0;
      cfg.wait_ticks      <= WAIT_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CC_STATUS:  cfg.cc_status_code  <= cfg_data[7:0];
        REG_BEGIN_CODE: cfg.begin_code      <= cfg_data[7:0];
        REG_END_CODE:   cfg.end_code        <= cfg_data[7:0];
        REG_GRANT_CODE: cfg.grant_code      <= cfg_data[7:0];
        REG_ABORT_CODE: cfg.abort_code      <= cfg_data[7:0];
        REG_SESSION_CH: cfg.session_channel <= cfg_data[6:0];
        REG_WAIT_TICKS: cfg.wait_ticks      <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  cfcs_front u_front (
    .req       (req),
    .cfg       (cfg),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_ready (front_ready)
  );

  cfcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_data   (front_cmd),
    .in_ready  (front_ready),
    .out_valid (back_valid),
    .out_data  (back_cmd),
    .out_ready (back_ready)
  );

  cfcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (back_valid),
    .cmd       (back_cmd),
    .cmd_ready (back_ready),
    .rsp       (rsp)
  );

endmodule

// ===== bench/credit_flow_control_sender_unit_tb.sv =====
// Self-checking bench for the credit flow control sender: directed cases, random sessions, stalls.
`timescale 1ns / 1ps

module credit_flow_control_sender_unit_tb
  import cfcs_pkg::*;
;

  localparam int          CYCLE_LIMIT   = 400000;
  localparam logic [2:0]  KIND_SPARE_LO = 3'd6;
  localparam logic [2:0]  KIND_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfcs_req_if req_if ();
  cfcs_rsp_if rsp_if ();

  credit_flow_control_sender_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the sender: configuration and link state
  cfg_t        cfg;
  logic        flow_active;
  logic [6:0]  flow_ch;
  logic [3:0]  credits;
  logic        ack_pending;
  logic [6:0]  ack_ch;
  logic        sess_failed;
  mode_t       wait_st;
  logic [16:0] ticks_waited;
  logic [23:0] held_msg;

  rsp_t pending_rsp[$];
  int   errors = 0;
  int   cycles = 0;
  bit   snd_idle_en = 1'b1;
  bit   rcv_idle_en = 1'b1;
  int   rcv_hold = 0;

  task automatic shadow_reset();
    cfg.cc_status_code  = 8'h00;
    cfg.begin_code      = 8'h00;
    cfg.end_code        = 8'h01;
    cfg.grant_code      = 8'h02;
    cfg.abort_code      = 8'h03;
    cfg.session_channel = 7'd0;
    cfg.wait_ticks      = WAIT_TICKS_RESET;
    flow_active  = 1'b0;
    flow_ch      = '0;
    credits      = '0;
    ack_pending  = 1'b0;
    ack_ch       = '0;
    sess_failed  = 1'b0;
    wait_st      = MODE_NONE;
    ticks_waited = '0;
    held_msg     = '0;
  endtask

  function automatic rsp_t compute_response(req_t r);
    rsp_t       o;
    logic       ctrl;
    logic       uses;
    logic [2:0] gch;
    logic [3:0] gcr;
    o   = '0;
    gch = r.rx_data[6:4];
    gcr = r.rx_data[3:0];
    if ((r.kind inside {[KIND_SEND:KIND_ABORT]}) && wait_st != MODE_NONE) begin
      o.report = REP_BUSY;
    end else if (r.kind == KIND_TICK) begin
      if (wait_st != MODE_NONE) begin
        if (ticks_waited < ELAPSED_MAX) ticks_waited = ticks_waited + 17'd1;
        if (ticks_waited > {1'b0, cfg.wait_ticks}) begin
          o.emit_valid = 1'b1;
          o.out_status = cfg.cc_status_code;
          o.out_data1  = cfg.abort_code;
          if (wait_st == MODE_CREDIT) begin
            o.out_data2 = {1'b0, flow_ch};
            o.report    = REP_DROPPED;
          end else begin
            o.out_data2 = {1'b0, ack_ch};
            ack_pending = 1'b0;
            o.report    = REP_DONE_FAILED;
          end
          flow_active = 1'b0;
          credits     = '0;
          sess_failed = 1'b1;
          wait_st     = MODE_NONE;
        end
      end
    end else if (r.kind == KIND_RX) begin
      // grant takes priority when grant and abort share a code
      if (r.rx_command == cfg.grant_code) begin
        if (gcr != 4'd0) begin
          if (ack_pending && {4'b0, gch} == ack_ch) ack_pending = 1'b0;
          if (flow_active && {4'b0, gch} == flow_ch) begin
            credits     = gcr;
            sess_failed = 1'b0;
          end
        end
      end else if (r.rx_command == cfg.abort_code) begin
        flow_active = 1'b0;
        credits     = '0;
        sess_failed = 1'b1;
        if (r.rx_data == {1'b0, ack_ch}) ack_pending = 1'b0;
      end
      if (wait_st == MODE_CREDIT) begin
        if (!(flow_active && credits == 4'd0)) begin
          if (!sess_failed) begin
            o.emit_valid = 1'b1;
            {o.out_status, o.out_data1, o.out_data2} = held_msg;
            if (credits > 4'd0) credits = credits - 4'd1;
            o.report = REP_SENT;
          end else begin
            o.report = REP_DROPPED;
          end
          wait_st = MODE_NONE;
        end
      end else if (wait_st != MODE_NONE && !ack_pending) begin
        if (wait_st == MODE_BEGIN) begin
          if (!sess_failed && ack_ch != cfg.session_channel) flow_active = 1'b1;
        end else if (ack_ch == flow_ch) begin
          flow_active = 1'b0;
          credits     = '0;
        end
        o.report = sess_failed ? REP_DONE_FAILED : REP_DONE_OK;
        wait_st  = MODE_NONE;
      end
    end else if (r.kind == KIND_SEND) begin
      ctrl = (r.send_status == cfg.cc_status_code) && (r.send_data1 >= cfg.begin_code)
             && (r.send_data1 <= cfg.abort_code);
      uses = flow_active && !ctrl;
      if (uses && credits == 4'd0) begin
        held_msg     = {r.send_status, r.send_data1, r.send_data2};
        wait_st      = MODE_CREDIT;
        ticks_waited = '0;
        o.report     = REP_WAITING;
      end else if (uses && sess_failed) begin
        o.report = REP_DROPPED;
      end else begin
        o.emit_valid = 1'b1;
        o.out_status = r.send_status;
        o.out_data1  = r.send_data1;
        o.out_data2  = r.send_data2;
        if (uses && credits > 4'd0) credits = credits - 4'd1;
        o.report = REP_SENT;
      end
    end else if (r.kind == KIND_BEGIN || r.kind == KIND_END) begin
      if (r.kind == KIND_BEGIN) begin
        flow_active = (r.channel != cfg.session_channel);
        flow_ch     = r.channel;
        credits     = '0;
        sess_failed = 1'b0;
      end
      ack_ch       = r.channel;
      ack_pending  = 1'b1;
      o.emit_valid = 1'b1;
      o.out_status = cfg.cc_status_code;
      o.out_data1  = (r.kind == KIND_BEGIN) ? cfg.begin_code : cfg.end_code;
      o.out_data2  = {1'b0, r.channel};
      wait_st      = (r.kind == KIND_BEGIN) ? MODE_BEGIN : MODE_END;
      ticks_waited = '0;
      o.report     = REP_WAITING;
    end else if (r.kind == KIND_ABORT) begin
      o.emit_valid = 1'b1;
      o.out_status = cfg.cc_status_code;
      o.out_data1  = cfg.abort_code;
      o.out_data2  = {1'b0, cfg.session_channel};
      ack_pending  = 1'b0;
      flow_active  = 1'b0;
      credits      = '0;
      sess_failed  = 1'b1;
    end
    o.failed_flag  = sess_failed;
    o.active_flag  = flow_active;
    o.credit_count = credits;
    return o;
  endfunction

  // Receiver: long hold-offs on request, otherwise random stalls
  initial begin : receiver
    int n;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rcv_hold > 0) begin
        n = rcv_hold;
        rcv_hold = 0;
        rsp_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        rsp_if.ready <= (!rcv_idle_en || $urandom_range(0, 99) >= 35);
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: response beat with none expected: actual %0h", $time, rsp_if.data);
      end else begin
        want = pending_rsp.pop_front();
        check_field("emit_valid", want.emit_valid, rsp_if.data.emit_valid);
        check_field("out_status", want.out_status, rsp_if.data.out_status);
        check_field("out_data1", want.out_data1, rsp_if.data.out_data1);
        check_field("out_data2", want.out_data2, rsp_if.data.out_data2);
        check_field("report", want.report, rsp_if.data.report);
        check_field("failed_flag", want.failed_flag, rsp_if.data.failed_flag);
        check_field("active_flag", want.active_flag, rsp_if.data.active_flag);
        check_field("credit_count", want.credit_count, rsp_if.data.credit_count);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one beat; returns at the edge that took it
  task automatic send_item(req_t it);
    int gap;
    @(negedge clk);
    if (snd_idle_en && $urandom_range(0, 99) < 35) begin
      gap = $urandom_range(1, 3);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_rsp.push_back(compute_response(it));
  endtask

  function automatic req_t rand_req();
    req_t r;
    r.kind        = 3'($urandom_range(0, 7));
    r.rx_command  = 8'($urandom);
    r.rx_data     = 8'($urandom);
    r.channel     = 7'($urandom);
    r.send_status = 8'($urandom);
    r.send_data1  = 8'($urandom);
    r.send_data2  = 8'($urandom);
    return r;
  endfunction

  task automatic send_tick();
    req_t r;
    r = rand_req();
    r.kind = KIND_TICK;
    send_item(r);
  endtask

  task automatic send_rx(logic [7:0] cmd, logic [7:0] data);
    req_t r;
    r = rand_req();
    r.kind       = KIND_RX;
    r.rx_command = cmd;
    r.rx_data    = data;
    send_item(r);
  endtask

  task automatic send_grant(logic [2:0] ch, logic [3:0] cr);
    send_rx(cfg.grant_code, {1'b0, ch, cr});
  endtask

  task automatic send_msg(logic [7:0] s, logic [7:0] d1, logic [7:0] d2);
    req_t r;
    r = rand_req();
    r.kind        = KIND_SEND;
    r.send_status = s;
    r.send_data1  = d1;
    r.send_data2  = d2;
    send_item(r);
  endtask

  task automatic send_flow(logic [2:0] kind, logic [6:0] ch);
    req_t r;
    r = rand_req();
    r.kind    = kind;
    r.channel = ch;
    send_item(r);
  endtask

  // Stop offering, wait out every response, then the pipeline latency
  task automatic wait_idle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_CC_STATUS:  cfg.cc_status_code  = val[7:0];
      REG_BEGIN_CODE: cfg.begin_code      = val[7:0];
      REG_END_CODE:   cfg.end_code        = val[7:0];
      REG_GRANT_CODE: cfg.grant_code      = val[7:0];
      REG_ABORT_CODE: cfg.abort_code      = val[7:0];
      REG_SESSION_CH: cfg.session_channel = val[6:0];
      REG_WAIT_TICKS: cfg.wait_ticks      = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] cc, logic [7:0] bc, logic [7:0] ec, logic [7:0] gc,
                            logic [7:0] ac, logic [6:0] sc, logic [15:0] wt);
    wait_idle();
    write_reg(REG_CC_STATUS, {8'h00, cc});
    write_reg(REG_BEGIN_CODE, {8'h00, bc});
    write_reg(REG_END_CODE, {8'h00, ec});
    write_reg(REG_GRANT_CODE, {8'h00, gc});
    write_reg(REG_ABORT_CODE, {8'h00, ac});
    write_reg(REG_SESSION_CH, {9'h000, sc});
    write_reg(REG_WAIT_TICKS, wt);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed sessions steered by the shadow state, with some noise
  task automatic random_items(int n);
    int         done_cnt;
    int         pick;
    req_t       r;
    logic [6:0] wch;
    done_cnt = 0;
    while (done_cnt < n) begin
      pick = $urandom_range(0, 99);
      r = rand_req();
      if (wait_st != MODE_NONE) begin
        wch = (wait_st == MODE_CREDIT) ? flow_ch : ack_ch;
        if (pick < 10 && cfg.wait_ticks <= 20) begin
          // run the wait out to its timeout
          repeat (cfg.wait_ticks + 1) send_tick();
          done_cnt += cfg.wait_ticks + 1;
          continue;
        end else if (pick < 70) begin
          r.kind          = KIND_RX;
          r.rx_command    = cfg.grant_code;
          r.rx_data[6:4]  = wch[2:0];
          r.rx_data[3:0]  = ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
        end else if (pick < 88) begin
          r.kind = KIND_TICK;
        end else if (pick < 94) begin
          r.kind = 3'($urandom_range(KIND_SEND, KIND_ABORT));
        end else begin
          r.kind       = KIND_RX;
          r.rx_command = cfg.abort_code;
          if (pick < 97) r.rx_data = {1'b0, wch};
        end
      end else if (!flow_active) begin
        if (pick < 55) begin
          r.kind    = KIND_BEGIN;
          r.channel = 7'($urandom_range(0, 7));
        end else if (pick < 62) begin
          r.kind = KIND_BEGIN;
        end else if (pick < 66) begin
          r.kind    = KIND_BEGIN;
          r.channel = cfg.session_channel;
        end else if (pick < 74) begin
          r.kind = KIND_END;
          if (pick < 70) r.channel = flow_ch;
        end else if (pick < 86) begin
          r.kind = KIND_SEND;
        end else if (pick < 90) begin
          r.kind = KIND_ABORT;
        end
      end else begin
        if (pick < 55) begin
          r.kind = KIND_SEND;
        end else if (pick < 65) begin
          r.kind        = KIND_SEND;
          r.send_status = cfg.cc_status_code;
          if (cfg.begin_code <= cfg.abort_code)
            r.send_data1 = 8'($urandom_range(cfg.begin_code, cfg.abort_code));
        end else if (pick < 73) begin
          r.kind    = KIND_END;
          r.channel = flow_ch;
        end else if (pick < 77) begin
          r.kind    = KIND_BEGIN;
          r.channel = 7'($urandom_range(0, 7));
        end else if (pick < 83) begin
          r.kind = KIND_TICK;
        end else if (pick < 90) begin
          r.kind         = KIND_RX;
          r.rx_command   = cfg.grant_code;
          r.rx_data[6:4] = flow_ch[2:0];
        end else if (pick < 93) begin
          r.kind = KIND_ABORT;
        end else if (pick < 96) begin
          r.kind       = KIND_RX;
          r.rx_command = cfg.abort_code;
        end
      end
      send_item(r);
      if (r.kind <= KIND_ABORT) done_cnt++;
    end
  endtask

  task automatic test_directed_defaults();
    req_t r;
    send_msg(8'hFF, 8'hFF, 8'hFF);
    r = '1;
    r.kind = KIND_SPARE_HI;
    send_item(r);
    r = '0;
    r.kind = KIND_SPARE_LO;
    send_item(r);
    send_tick();
    send_flow(KIND_BEGIN, 7'd3);
    send_msg(8'h00, 8'h80, 8'h00);       // refused while waiting
    send_grant(3'd3, 4'd0);              // zero credits: no effect
    send_grant(3'd3, 4'd1);
    send_msg(8'h00, 8'h80, 8'h00);
    send_msg(8'h00, 8'h02, 8'h11);       // control beat, free of credit
    send_msg(8'h12, 8'h34, 8'h56);       // held for credit
    send_tick();
    send_grant(3'd3, 4'd15);
    send_flow(KIND_END, 7'd3);
    send_grant(3'd3, 4'd2);
    send_flow(KIND_ABORT, 7'd0);
    send_flow(KIND_BEGIN, 7'd0);         // load session: credits stay off
    send_rx(cfg.abort_code, 8'h00);
  endtask

  task automatic test_directed_corner_codes();
    // grant and abort share a code, command range misordered, wait limit of one tick
    set_config(8'hFF, 8'hC0, 8'hC1, 8'h05, 8'h05, 7'd127, 16'd1);
    send_flow(KIND_BEGIN, 7'd7);
    send_rx(8'h05, 8'h71);
    send_msg(8'h01, 8'h02, 8'h03);
    send_flow(KIND_END, 7'd7);           // goes out with no credit left
    send_tick();
    send_tick();
    send_flow(KIND_BEGIN, 7'd7);
    send_grant(3'd7, 4'd1);
    send_msg(8'hFF, 8'hC0, 8'h00);
    send_msg(8'hFF, 8'hC0, 8'h00);
    send_tick();
    send_tick();
  endtask

  task automatic test_random_phase(logic [7:0] cc, logic [7:0] bc, logic [7:0] ec,
                                   logic [7:0] gc, logic [7:0] ac, logic [6:0] sc,
                                   logic [15:0] wt, int n);
    set_config(cc, bc, ec, gc, ac, sc, wt);
    random_items(n);
  endtask

  task automatic test_full_rate();
    wait_idle();
    snd_idle_en = 1'b0;
    rcv_idle_en = 1'b0;
    random_items(150);
    wait_idle();
    snd_idle_en = 1'b1;
    rcv_idle_en = 1'b1;
  endtask

  task automatic test_back_pressure();
    wait_idle();
    snd_idle_en = 1'b0;
    rcv_hold    = 60;
    random_items(30);
    // pause until every response is back
    wait_idle();
    snd_idle_en = 1'b1;
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    shadow_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_defaults();
    test_directed_corner_codes();
    test_random_phase(8'hB0, 8'h10, 8'h11, 8'h12, 8'h13, 7'd5, 16'd6, 250);
    test_full_rate();
    test_back_pressure();
    test_random_phase(8'h00, 8'h00, 8'h01, 8'h02, 8'hFF, 7'd0, 16'd0, 200);
    test_random_phase(8'hFF, 8'hF0, 8'hF1, 8'hF2, 8'hF3, 7'd127, 16'hFFFF, 200);
    test_random_phase(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 7'($urandom_range(0, 7)),
                      16'($urandom_range(0, 15)), 200);

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
